// ----- rtl/core/solwt_pkg.sv -----
// ----------------------------------------------------------------------------
// solwt_pkg
// Shared types and constants of the ownership lock with inactivity timeout.
// ----------------------------------------------------------------------------
package solwt_pkg;

  localparam int unsigned OWNER_W   = 8;
  localparam int unsigned IDLE_W    = 17;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned LENGTH_W  = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned NUM_DISC  = 4;

  localparam logic [IDLE_W-1:0]    IDLE_MAX        = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd5000;
  localparam logic [LENGTH_W-1:0]  LENGTH_RESET    = 10'd64;
  localparam logic [OWNER_W-1:0]   NO_OWNER        = '0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_CMD_CHECK  = 3'd1,
    OP_STREAM     = 3'd2,
    OP_CONNECT    = 3'd3,
    OP_DISCONNECT = 3'd4,
    OP_HEARTBEAT  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_TIMEOUT        = 3'd0,
    REG_REQ_LENGTH     = 3'd1,
    REG_DISCOVERY      = 3'd2,
    REG_SESSION_OP     = 3'd3,
    REG_SESSION_STATUS = 3'd4,
    REG_SESSION_CONN   = 3'd5,
    REG_WIFI_OP        = 3'd6,
    REG_WIFI_STATUS    = 3'd7
  } reg_idx_t;

endpackage

// ----- rtl/core/session_owner_lock_with_timeout.sv -----
// ----------------------------------------------------------------------------
// session_owner_lock_with_timeout
// Grants a shared link to one owning source and releases it after idling.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while in_stall is low and
// returns exactly one result per request, in order. A request is first
// captured in an input register. While it is held there, one pass does the
// expiry test, the operation and the update of the owner and the idle count,
// and loads the result into the output register once the output can advance.
// The result is held there until it is taken at a rising edge when the output
// is not stalled. A stalled output holds both registers and raises in_stall
// only while the input register is also full, so the input side is never held
// longer than the output side is stalled. The owner and idle count are updated
// in that same pass, so back-to-back requests always see the state left by
// the one before. The user must write configuration registers over the APB
// port only while no request is in flight; the block does not enforce this.
module session_owner_lock_with_timeout (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [solwt_pkg::OP_W-1:0]      in_operation,
  input  logic [solwt_pkg::OWNER_W-1:0]   in_source,
  input  logic [solwt_pkg::LENGTH_W-1:0]  in_cmd_length,
  input  logic [solwt_pkg::BYTE_W-1:0]    in_cmd_opcode,
  input  logic [solwt_pkg::BYTE_W-1:0]    in_cmd_subcode,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_allowed,
  output logic [solwt_pkg::OWNER_W-1:0]   out_owner,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [solwt_pkg::ADDR_W-1:0]    paddr,
  input  logic [solwt_pkg::DATA_W-1:0]    pwdata,
  output logic [solwt_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  // Configuration registers
  logic [solwt_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [solwt_pkg::LENGTH_W-1:0]  req_length_r;
  logic [solwt_pkg::DATA_W-1:0]    discovery_r;
  logic [solwt_pkg::BYTE_W-1:0]    session_op_r;
  logic [solwt_pkg::BYTE_W-1:0]    session_status_r;
  logic [solwt_pkg::BYTE_W-1:0]    session_conn_r;
  logic [solwt_pkg::BYTE_W-1:0]    wifi_op_r;
  logic [solwt_pkg::BYTE_W-1:0]    wifi_status_r;

  // Input stage
  logic                            s1_valid_r;
  solwt_pkg::op_t                  s1_op_r;
  logic [solwt_pkg::OWNER_W-1:0]   s1_source_r;
  logic [solwt_pkg::LENGTH_W-1:0]  s1_length_r;
  logic [solwt_pkg::BYTE_W-1:0]    s1_opcode_r;
  logic [solwt_pkg::BYTE_W-1:0]    s1_subcode_r;

  // Lock state
  logic [solwt_pkg::OWNER_W-1:0]   owner_r;
  logic [solwt_pkg::OWNER_W-1:0]   owner_nxt;
  logic [solwt_pkg::IDLE_W-1:0]    idle_r;
  logic [solwt_pkg::IDLE_W-1:0]    idle_nxt;

  // Output stage
  logic                            out_valid_r;
  logic                            allowed_r;
  logic                            allowed_nxt;
  logic [solwt_pkg::OWNER_W-1:0]   out_owner_r;

  logic                            advance;
  logic                            fire;
  logic                            cfg_write;
  solwt_pkg::reg_idx_t             cfg_idx;
  logic [solwt_pkg::OWNER_W-1:0]   owner_eff;
  logic                            len_ok;
  logic                            is_session;
  logic                            is_discovery;
  logic                            is_owner;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  assign out_valid   = out_valid_r;
  assign out_allowed = allowed_r;
  assign out_owner   = out_owner_r;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_idx   = solwt_pkg::reg_idx_t'(paddr[solwt_pkg::ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      solwt_pkg::REG_TIMEOUT:        prdata = {{(solwt_pkg::DATA_W-solwt_pkg::TIMEOUT_W){1'b0}},
                                               timeout_r};
      solwt_pkg::REG_REQ_LENGTH:     prdata = {{(solwt_pkg::DATA_W-solwt_pkg::LENGTH_W){1'b0}},
                                               req_length_r};
      solwt_pkg::REG_DISCOVERY:      prdata = discovery_r;
      solwt_pkg::REG_SESSION_OP:     prdata = {{(solwt_pkg::DATA_W-solwt_pkg::BYTE_W){1'b0}},
                                               session_op_r};
      solwt_pkg::REG_SESSION_STATUS: prdata = {{(solwt_pkg::DATA_W-solwt_pkg::BYTE_W){1'b0}},
                                               session_status_r};
      solwt_pkg::REG_SESSION_CONN:   prdata = {{(solwt_pkg::DATA_W-solwt_pkg::BYTE_W){1'b0}},
                                               session_conn_r};
      solwt_pkg::REG_WIFI_OP:        prdata = {{(solwt_pkg::DATA_W-solwt_pkg::BYTE_W){1'b0}},
                                               wifi_op_r};
      solwt_pkg::REG_WIFI_STATUS:    prdata = {{(solwt_pkg::DATA_W-solwt_pkg::BYTE_W){1'b0}},
                                               wifi_status_r};
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r        <= solwt_pkg::TIMEOUT_RESET;
      req_length_r     <= solwt_pkg::LENGTH_RESET;
      discovery_r      <= '0;
      session_op_r     <= '0;
      session_status_r <= '0;
      session_conn_r   <= '0;
      wifi_op_r        <= '0;
      wifi_status_r    <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        solwt_pkg::REG_TIMEOUT:        timeout_r        <= pwdata[solwt_pkg::TIMEOUT_W-1:0];
        solwt_pkg::REG_REQ_LENGTH:     req_length_r     <= pwdata[solwt_pkg::LENGTH_W-1:0];
        solwt_pkg::REG_DISCOVERY:      discovery_r      <= pwdata;
        solwt_pkg::REG_SESSION_OP:     session_op_r     <= pwdata[solwt_pkg::BYTE_W-1:0];
        solwt_pkg::REG_SESSION_STATUS: session_status_r <= pwdata[solwt_pkg::BYTE_W-1:0];
        solwt_pkg::REG_SESSION_CONN:   session_conn_r   <= pwdata[solwt_pkg::BYTE_W-1:0];
        solwt_pkg::REG_WIFI_OP:        wifi_op_r        <= pwdata[solwt_pkg::BYTE_W-1:0];
        solwt_pkg::REG_WIFI_STATUS:    wifi_status_r    <= pwdata[solwt_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r      <= solwt_pkg::op_t'(in_operation);
      s1_source_r  <= in_source;
      s1_length_r  <= in_cmd_length;
      s1_opcode_r  <= in_cmd_opcode;
      s1_subcode_r <= in_cmd_subcode;
    end
  end

  // ---------------------------------------------------------------------------
  // Lock evaluation
  // ---------------------------------------------------------------------------
  always_comb begin
    is_discovery = 1'b0;
    for (int k = 0; k < solwt_pkg::NUM_DISC; k++) begin
      if (discovery_r[k*solwt_pkg::BYTE_W +: solwt_pkg::BYTE_W] == s1_opcode_r) begin
        is_discovery = 1'b1;
      end
    end
  end

  // A stale owner is dropped before the operation sees the state.
  assign owner_eff  = (owner_r != solwt_pkg::NO_OWNER &&
                       idle_r > {1'b0, timeout_r}) ? solwt_pkg::NO_OWNER : owner_r;
  assign is_owner   = (owner_eff != solwt_pkg::NO_OWNER) && (owner_eff == s1_source_r);
  assign len_ok     = (s1_length_r == req_length_r);
  assign is_session = len_ok && (s1_opcode_r == session_op_r);

  always_comb begin
    owner_nxt   = owner_eff;
    idle_nxt    = idle_r;
    allowed_nxt = 1'b0;
    case (s1_op_r)
      solwt_pkg::OP_TICK: begin
        if (idle_r != solwt_pkg::IDLE_MAX) begin
          idle_nxt = idle_r + 1'b1;
        end
      end
      solwt_pkg::OP_CMD_CHECK: begin
        if (is_session && s1_subcode_r == session_conn_r) begin
          allowed_nxt = (owner_eff == solwt_pkg::NO_OWNER) || (owner_eff == s1_source_r);
        end else if ((is_session && s1_subcode_r == session_status_r) ||
                     (len_ok && is_discovery) ||
                     (len_ok && s1_opcode_r == wifi_op_r &&
                      s1_subcode_r == wifi_status_r)) begin
          allowed_nxt = 1'b1;
        end else if (is_owner) begin
          // Any other command from the owner counts as activity.
          idle_nxt    = '0;
          allowed_nxt = 1'b1;
        end
      end
      solwt_pkg::OP_STREAM: begin
        allowed_nxt = is_owner;
      end
      solwt_pkg::OP_CONNECT: begin
        if (s1_source_r != solwt_pkg::NO_OWNER &&
            (owner_eff == solwt_pkg::NO_OWNER || owner_eff == s1_source_r)) begin
          owner_nxt   = s1_source_r;
          idle_nxt    = '0;
          allowed_nxt = 1'b1;
        end
      end
      solwt_pkg::OP_DISCONNECT: begin
        if (owner_eff == solwt_pkg::NO_OWNER) begin
          allowed_nxt = 1'b1;
        end else if (owner_eff == s1_source_r) begin
          owner_nxt   = solwt_pkg::NO_OWNER;
          allowed_nxt = 1'b1;
        end
      end
      solwt_pkg::OP_HEARTBEAT: begin
        if (is_owner) begin
          idle_nxt    = '0;
          allowed_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= solwt_pkg::NO_OWNER;
      idle_r  <= '0;
    end else if (fire) begin
      owner_r <= owner_nxt;
      idle_r  <= idle_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      allowed_r   <= allowed_nxt;
      out_owner_r <= owner_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline can move");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request produced no result");

  a_owner_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(owner_r) && $stable(idle_r)))
    else $error("lock state changed without a request");

  a_connect_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_op_r == solwt_pkg::OP_CONNECT && allowed_nxt) |=>
      (idle_r == '0 && owner_r != solwt_pkg::NO_OWNER))
    else $error("successful connect left no owner or a nonzero idle count");

  a_result_owner_matches: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_owner_r == owner_r))
    else $error("reported owner differs from the lock state");

endmodule

// ----- tb/sv/session_owner_lock_with_timeout_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_owner_lock_with_timeout_tb
// Self-checking testbench for the ownership lock with inactivity timeout.
// A scoreboard keeps its own copy of the owner, the idle count and the
// configuration, and works out the result of every accepted request. Results
// are compared in order. Directed requests cover the corner cases. Random
// phases follow under several register settings, with random gaps and
// stalls. A short tick run at the end lets an owner lapse on its timeout.
// ----------------------------------------------------------------------------
module session_owner_lock_with_timeout_tb;

  localparam logic [solwt_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [solwt_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned SOAK_TICKS = 6;

  typedef struct packed {
    logic                           allowed;
    logic [solwt_pkg::OWNER_W-1:0]  owner;
  } grant_t;

  class lock_scoreboard;
    logic [solwt_pkg::TIMEOUT_W-1:0] timeout;
    logic [solwt_pkg::LENGTH_W-1:0]  req_len;
    logic [solwt_pkg::DATA_W-1:0]    discovery;
    logic [solwt_pkg::BYTE_W-1:0]    sess_op;
    logic [solwt_pkg::BYTE_W-1:0]    sess_status;
    logic [solwt_pkg::BYTE_W-1:0]    sess_conn;
    logic [solwt_pkg::BYTE_W-1:0]    wifi_op;
    logic [solwt_pkg::BYTE_W-1:0]    wifi_status;
    logic [solwt_pkg::OWNER_W-1:0]   owner;
    logic [solwt_pkg::IDLE_W-1:0]    idle_ticks;
    grant_t                          expected_grants[$];
    int unsigned                     errors;

    function new();
      timeout     = solwt_pkg::TIMEOUT_RESET;
      req_len     = solwt_pkg::LENGTH_RESET;
      discovery   = '0;
      sess_op     = '0;
      sess_status = '0;
      sess_conn   = '0;
      wifi_op     = '0;
      wifi_status = '0;
      owner       = solwt_pkg::NO_OWNER;
      idle_ticks  = '0;
      errors      = 0;
    endfunction

    function void set_register(solwt_pkg::reg_idx_t idx,
                               logic [solwt_pkg::DATA_W-1:0] value);
      case (idx)
        solwt_pkg::REG_TIMEOUT:        timeout     = value[solwt_pkg::TIMEOUT_W-1:0];
        solwt_pkg::REG_REQ_LENGTH:     req_len     = value[solwt_pkg::LENGTH_W-1:0];
        solwt_pkg::REG_DISCOVERY:      discovery   = value;
        solwt_pkg::REG_SESSION_OP:     sess_op     = value[solwt_pkg::BYTE_W-1:0];
        solwt_pkg::REG_SESSION_STATUS: sess_status = value[solwt_pkg::BYTE_W-1:0];
        solwt_pkg::REG_SESSION_CONN:   sess_conn   = value[solwt_pkg::BYTE_W-1:0];
        solwt_pkg::REG_WIFI_OP:        wifi_op     = value[solwt_pkg::BYTE_W-1:0];
        solwt_pkg::REG_WIFI_STATUS:    wifi_status = value[solwt_pkg::BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [solwt_pkg::DATA_W-1:0] register_value(solwt_pkg::reg_idx_t idx);
      case (idx)
        solwt_pkg::REG_TIMEOUT:        return solwt_pkg::DATA_W'(timeout);
        solwt_pkg::REG_REQ_LENGTH:     return solwt_pkg::DATA_W'(req_len);
        solwt_pkg::REG_DISCOVERY:      return discovery;
        solwt_pkg::REG_SESSION_OP:     return solwt_pkg::DATA_W'(sess_op);
        solwt_pkg::REG_SESSION_STATUS: return solwt_pkg::DATA_W'(sess_status);
        solwt_pkg::REG_SESSION_CONN:   return solwt_pkg::DATA_W'(sess_conn);
        solwt_pkg::REG_WIFI_OP:        return solwt_pkg::DATA_W'(wifi_op);
        default:                       return solwt_pkg::DATA_W'(wifi_status);
      endcase
    endfunction

    function void mismatch(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // Command filter. Session connect requests are only tested, never granted
    // as a state change; the owner fallback refreshes the idle count.
    function logic command_allowed(logic [solwt_pkg::OWNER_W-1:0] src,
                                   logic [solwt_pkg::LENGTH_W-1:0] len,
                                   logic [solwt_pkg::BYTE_W-1:0] opc,
                                   logic [solwt_pkg::BYTE_W-1:0] sub);
      logic len_ok;
      logic session;
      logic listed;
      len_ok  = (len == req_len);
      session = len_ok && (opc == sess_op);
      listed  = 1'b0;
      for (int k = 0; k < solwt_pkg::NUM_DISC; k++)
        if (discovery[8*k +: 8] == opc) listed = 1'b1;
      if (session && sub == sess_conn)
        return (owner == solwt_pkg::NO_OWNER) || (owner == src);
      if (session && sub == sess_status) return 1'b1;
      if (len_ok && listed) return 1'b1;
      if (len_ok && opc == wifi_op && sub == wifi_status) return 1'b1;
      if (owner == solwt_pkg::NO_OWNER || owner != src) return 1'b0;
      idle_ticks = '0;
      return 1'b1;
    endfunction

    function void note_request(logic [solwt_pkg::OP_W-1:0] op,
                               logic [solwt_pkg::OWNER_W-1:0] src,
                               logic [solwt_pkg::LENGTH_W-1:0] len,
                               logic [solwt_pkg::BYTE_W-1:0] opc,
                               logic [solwt_pkg::BYTE_W-1:0] sub);
      grant_t g;
      g.allowed = 1'b0;
      if (owner != solwt_pkg::NO_OWNER && idle_ticks > solwt_pkg::IDLE_W'(timeout))
        owner = solwt_pkg::NO_OWNER;
      case (op)
        solwt_pkg::OP_TICK:
          if (idle_ticks != solwt_pkg::IDLE_MAX) idle_ticks = idle_ticks + 1'b1;
        solwt_pkg::OP_CMD_CHECK: g.allowed = command_allowed(src, len, opc, sub);
        solwt_pkg::OP_STREAM: g.allowed = (owner != solwt_pkg::NO_OWNER) && (owner == src);
        solwt_pkg::OP_CONNECT: begin
          if (src != solwt_pkg::NO_OWNER &&
              (owner == solwt_pkg::NO_OWNER || owner == src)) begin
            owner      = src;
            idle_ticks = '0;
            g.allowed  = 1'b1;
          end
        end
        solwt_pkg::OP_DISCONNECT: begin
          if (owner == solwt_pkg::NO_OWNER) begin
            g.allowed = 1'b1;
          end else if (owner == src) begin
            owner     = solwt_pkg::NO_OWNER;
            g.allowed = 1'b1;
          end
        end
        solwt_pkg::OP_HEARTBEAT: begin
          if (src != solwt_pkg::NO_OWNER && owner == src) begin
            idle_ticks = '0;
            g.allowed  = 1'b1;
          end
        end
        default: ;
      endcase
      g.owner = owner;
      expected_grants.push_back(g);
    endfunction

    function void check_result(logic allowed, logic [solwt_pkg::OWNER_W-1:0] owner_seen);
      grant_t want;
      if (expected_grants.size() == 0) begin
        mismatch("result with no request outstanding", '0, 32'({allowed, owner_seen}));
        return;
      end
      want = expected_grants.pop_front();
      if (allowed !== want.allowed) mismatch("allowed", 32'(want.allowed), 32'(allowed));
      if (owner_seen !== want.owner) mismatch("owner", 32'(want.owner), 32'(owner_seen));
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [solwt_pkg::OP_W-1:0]       in_operation = '0;
  logic [solwt_pkg::OWNER_W-1:0]    in_source = '0;
  logic [solwt_pkg::LENGTH_W-1:0]   in_cmd_length = '0;
  logic [solwt_pkg::BYTE_W-1:0]     in_cmd_opcode = '0;
  logic [solwt_pkg::BYTE_W-1:0]     in_cmd_subcode = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_allowed;
  logic [solwt_pkg::OWNER_W-1:0]    out_owner;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [solwt_pkg::ADDR_W-1:0]     paddr = '0;
  logic [solwt_pkg::DATA_W-1:0]     pwdata = '0;
  logic [solwt_pkg::DATA_W-1:0]     prdata;
  logic                             pready;

  lock_scoreboard sb = new();
  bit             idling = 1'b1;
  int unsigned    stall_left = 0;
  int unsigned    quiet_cycles = 0;

  session_owner_lock_with_timeout DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_source      (in_source),
    .in_cmd_length  (in_cmd_length),
    .in_cmd_opcode  (in_cmd_opcode),
    .in_cmd_subcode (in_cmd_subcode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_allowed    (out_allowed),
    .out_owner      (out_owner),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check accepted results and stall in random bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_allowed, out_owner);
      if (stall_left != 0) begin
        stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Every request must be sent from right after a rising edge.
  task automatic send(logic [solwt_pkg::OP_W-1:0] op, logic [solwt_pkg::OWNER_W-1:0] src,
                      logic [solwt_pkg::LENGTH_W-1:0] len,
                      logic [solwt_pkg::BYTE_W-1:0] opc,
                      logic [solwt_pkg::BYTE_W-1:0] sub);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_source      <= src;
    in_cmd_length  <= len;
    in_cmd_opcode  <= opc;
    in_cmd_subcode <= sub;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, src, len, opc, sub);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write a register, then read it back.
  task automatic write_reg(solwt_pkg::reg_idx_t idx, logic [solwt_pkg::DATA_W-1:0] value);
    logic [solwt_pkg::DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    if (readback !== sb.register_value(idx))
      sb.mismatch("register readback", sb.register_value(idx), readback);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [solwt_pkg::TIMEOUT_W-1:0] tmo,
                           logic [solwt_pkg::LENGTH_W-1:0] len,
                           logic [solwt_pkg::DATA_W-1:0] disc,
                           logic [solwt_pkg::BYTE_W-1:0] s_op,
                           logic [solwt_pkg::BYTE_W-1:0] s_st,
                           logic [solwt_pkg::BYTE_W-1:0] s_cn,
                           logic [solwt_pkg::BYTE_W-1:0] w_op,
                           logic [solwt_pkg::BYTE_W-1:0] w_st);
    write_reg(solwt_pkg::REG_TIMEOUT, solwt_pkg::DATA_W'(tmo));
    write_reg(solwt_pkg::REG_REQ_LENGTH, solwt_pkg::DATA_W'(len));
    write_reg(solwt_pkg::REG_DISCOVERY, disc);
    write_reg(solwt_pkg::REG_SESSION_OP, solwt_pkg::DATA_W'(s_op));
    write_reg(solwt_pkg::REG_SESSION_STATUS, solwt_pkg::DATA_W'(s_st));
    write_reg(solwt_pkg::REG_SESSION_CONN, solwt_pkg::DATA_W'(s_cn));
    write_reg(solwt_pkg::REG_WIFI_OP, solwt_pkg::DATA_W'(w_op));
    write_reg(solwt_pkg::REG_WIFI_STATUS, solwt_pkg::DATA_W'(w_st));
  endtask

  // Mostly a handful of competing sources, sometimes none or any id.
  function automatic logic [solwt_pkg::OWNER_W-1:0] pick_source();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return solwt_pkg::OWNER_W'($urandom_range(1, 3));
    if (roll == 7) return solwt_pkg::NO_OWNER;
    return solwt_pkg::OWNER_W'($urandom);
  endfunction

  task automatic random_request();
    logic [solwt_pkg::OWNER_W-1:0]  src;
    logic [solwt_pkg::LENGTH_W-1:0] len;
    logic [solwt_pkg::BYTE_W-1:0]   opc;
    logic [solwt_pkg::BYTE_W-1:0]   sub;
    int unsigned                    roll;
    int unsigned                    k;
    src  = pick_source();
    len  = solwt_pkg::LENGTH_W'($urandom);
    opc  = solwt_pkg::BYTE_W'($urandom);
    sub  = solwt_pkg::BYTE_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      repeat ($urandom_range(1, 4)) send(solwt_pkg::OP_TICK, src, len, opc, sub);
    end else if (roll < 55) begin
      // Commands mostly hit the configured opcodes so that every branch of
      // the filter is reached.
      if ($urandom_range(0, 9) < 7) len = sb.req_len;
      case ($urandom_range(0, 4))
        0: opc = sb.sess_op;
        1: opc = sb.wifi_op;
        2: begin
          k   = $urandom_range(0, solwt_pkg::NUM_DISC - 1);
          opc = sb.discovery[8*k +: 8];
        end
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: sub = sb.sess_status;
        1: sub = sb.sess_conn;
        2: sub = sb.wifi_status;
        default: ;
      endcase
      send(solwt_pkg::OP_CMD_CHECK, src, len, opc, sub);
    end else if (roll < 65) begin
      send(solwt_pkg::OP_STREAM, src, len, opc, sub);
    end else if (roll < 80) begin
      send(solwt_pkg::OP_CONNECT, src, len, opc, sub);
    end else if (roll < 88) begin
      send(solwt_pkg::OP_DISCONNECT, src, len, opc, sub);
    end else if (roll < 98) begin
      send(solwt_pkg::OP_HEARTBEAT, src, len, opc, sub);
    end else begin
      send($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI, src, len, opc, sub);
    end
  endtask

  // Random requests in stretches that are each chosen at random to idle or not.
  task automatic random_phase(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) idling = ($urandom_range(0, 3) != 0);
      random_request();
    end
  endtask

  // Ends the run when nothing moves for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("session_owner_lock_with_timeout_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: every code is zero, so session connect wins the filter.
    random_phase(50);
    drain();

    configure(16'd3, 10'd16, 32'h1122_3344, 8'h50, 8'h01, 8'h02, 8'h60, 8'h07);
    idling = 1'b1;
    send(solwt_pkg::OP_CONNECT, 8'd0, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_DISCONNECT, 8'd5, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_STREAM, 8'd0, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_CMD_CHECK, 8'd7, 10'd16, 8'h50, 8'h02);
    send(solwt_pkg::OP_CONNECT, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_CONNECT, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_CONNECT, 8'd2, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_CMD_CHECK, 8'd2, 10'd16, 8'h50, 8'h02);
    send(solwt_pkg::OP_CMD_CHECK, 8'd2, 10'd16, 8'h50, 8'h01);
    send(solwt_pkg::OP_CMD_CHECK, 8'd9, 10'd16, 8'h44, 8'hAA);
    send(solwt_pkg::OP_CMD_CHECK, 8'd9, 10'd16, 8'h11, 8'h55);
    send(solwt_pkg::OP_CMD_CHECK, 8'd9, 10'd16, 8'h60, 8'h07);
    send(solwt_pkg::OP_CMD_CHECK, 8'd9, 10'd16, 8'h60, 8'h08);
    send(solwt_pkg::OP_CMD_CHECK, 8'd1, 10'd17, 8'h50, 8'h02);
    send(solwt_pkg::OP_STREAM, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_STREAM, 8'd2, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_HEARTBEAT, 8'd2, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_HEARTBEAT, 8'd0, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_HEARTBEAT, 8'd1, 10'd0, 8'h00, 8'h00);
    send(OP_SPARE_LO, 8'd1, 10'd0, 8'h00, 8'h00);
    send(OP_SPARE_HI, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_DISCONNECT, 8'd2, 10'd0, 8'h00, 8'h00);
    // Four ticks pass the timeout of three; the release shows on the next
    // request, not on the tick that crosses it.
    repeat (4) send(solwt_pkg::OP_TICK, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_STREAM, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_CONNECT, 8'd255, 10'd1023, 8'hFF, 8'hFF);
    send(solwt_pkg::OP_CMD_CHECK, 8'd255, 10'd1023, 8'hFF, 8'hFF);
    send(solwt_pkg::OP_DISCONNECT, 8'd255, 10'd1023, 8'hFF, 8'hFF);
    random_phase(80);
    drain();

    // Zero timeout and all-ones codes but for session connect.
    configure(16'd0, 10'd0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    send(solwt_pkg::OP_CONNECT, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_STREAM, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_TICK, 8'd1, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_STREAM, 8'd1, 10'd0, 8'h00, 8'h00);
    random_phase(80);
    drain();

    configure(16'hFFFF, 10'd1023, 32'h0000_0000, 8'h00, 8'h80, 8'h40, 8'h00, 8'h20);
    random_phase(80);
    drain();

    configure(solwt_pkg::TIMEOUT_W'($urandom_range(0, 10)),
              solwt_pkg::LENGTH_W'($urandom), $urandom,
              solwt_pkg::BYTE_W'($urandom), solwt_pkg::BYTE_W'($urandom),
              solwt_pkg::BYTE_W'($urandom), solwt_pkg::BYTE_W'($urandom),
              solwt_pkg::BYTE_W'($urandom));
    random_phase(60);
    idling = 1'b0;
    for (int unsigned i = 0; i < 40; i++) random_request();
    drain();

    // Short tick run: the owner lapses once the idle count passes the
    // timeout of four, and the next requests see no owner.
    configure(16'd4, 10'd64, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send(solwt_pkg::OP_CONNECT, 8'd9, 10'd0, 8'h00, 8'h00);
    repeat (SOAK_TICKS) send(solwt_pkg::OP_TICK, 8'd9, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_STREAM, 8'd9, 10'd0, 8'h00, 8'h00);
    send(solwt_pkg::OP_CONNECT, 8'd9, 10'd0, 8'h00, 8'h00);
    drain();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("session_owner_lock_with_timeout_tb: done, clean");
    else
      $display("session_owner_lock_with_timeout_tb: done, errors");
    $finish;
  end

endmodule
